// ===== src/byte_ring_fifo_chunked_assert.svh =====
// Assertion macros for the checker file of the byte ring FIFO.
// Depends on nothing; the including scope must declare clk and rst.
`ifndef BYTE_RING_FIFO_CHUNKED_ASSERT_SVH
`define BYTE_RING_FIFO_CHUNKED_ASSERT_SVH

// Assertion that is switched off while reset is high.
`define BRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also checked while reset is high.
`define BRF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/brf_pkg.sv =====
// Package of the byte ring FIFO: sizes, command codes and transaction types.
// Used by every module of the block; depends on nothing.
package brf_pkg;

  localparam int RING_SLOTS = 256;
  localparam int MAX_CHUNK  = 8;
  localparam int ADDR_W     = $clog2(RING_SLOTS);
  localparam int IDX_W      = $clog2(MAX_CHUNK);
  localparam int CNT_W      = 4;
  localparam int Q_DEPTH    = 2;

  localparam logic [7:0] CAP_RESET = 8'd255;
  localparam logic       CMD_PUSH  = 1'b0;
  localparam logic       CMD_POP   = 1'b1;

  // Request transaction as it arrives on the input channel.
  typedef struct packed {
    logic       command;
    logic [3:0] length;
    logic [7:0] in_byte_0;
    logic [7:0] in_byte_1;
    logic [7:0] in_byte_2;
    logic [7:0] in_byte_3;
    logic [7:0] in_byte_4;
    logic [7:0] in_byte_5;
    logic [7:0] in_byte_6;
    logic [7:0] in_byte_7;
  } in_item_t;

  // Response transaction as it leaves on the output channel.
  typedef struct packed {
    logic       accepted;
    logic [7:0] out_byte_0;
    logic [7:0] out_byte_1;
    logic [7:0] out_byte_2;
    logic [7:0] out_byte_3;
    logic [7:0] out_byte_4;
    logic [7:0] out_byte_5;
    logic [7:0] out_byte_6;
    logic [7:0] out_byte_7;
    logic [7:0] space_free;
    logic [7:0] bytes_held;
  } out_item_t;

  // Classified work passed from the front end to the memory back end.
  typedef struct packed {
    logic                           is_pop;
    logic                           do_mem;
    logic [CNT_W-1:0]               len;
    logic [ADDR_W-1:0]              addr;
    logic [MAX_CHUNK-1:0][7:0]      data;
    logic                           accepted;
    logic [7:0]                     space_free;
    logic [7:0]                     bytes_held;
  } work_t;

endpackage

// ===== src/byte_ring_fifo_chunked.sv =====
// Byte ring FIFO: push or pop up to eight bytes per transaction.
// The back end handles one transaction at a time through the single byte-wide port
// of the ring memory and takes no new one until the last is answered; refused and
// zero-length transactions skip the memory. A two-entry queue decouples the front.
// Reset (synchronous): capacity 255, buffer empty, queue and response cleared.
module byte_ring_fifo_chunked (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  brf_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output brf_pkg::out_item_t rsp,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  logic [7:0]     cap;
  logic           wq_valid;
  logic           wq_ready;
  brf_pkg::work_t wq_data;
  logic           q_valid;
  logic           q_ready;
  brf_pkg::work_t q_data;

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= brf_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  brf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .cfg_clear (cfg_wr_en),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .wq_valid  (wq_valid),
    .wq_ready  (wq_ready),
    .wq_data   (wq_data)
  );

  brf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (wq_valid),
    .push_ready (wq_ready),
    .push_data  (wq_data),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  brf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cap       (cap),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== src/brf_front.sv =====
// Front end: accepts requests, decides accept or refuse and keeps positions.
// Depends on brf_pkg.
module brf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic [7:0]       cap,
  input  logic             cfg_clear,
  input  logic             req_valid,
  output logic             req_ready,
  input  brf_pkg::in_item_t req,
  output logic             wq_valid,
  input  logic             wq_ready,
  output brf_pkg::work_t   wq_data
);

  logic [brf_pkg::ADDR_W-1:0] wr_pos;
  logic [brf_pkg::ADDR_W-1:0] rd_pos;
  logic [7:0]                 held;

  logic [brf_pkg::ADDR_W-1:0] wr_pos_next;
  logic [brf_pkg::ADDR_W-1:0] rd_pos_next;
  logic [7:0]                 held_next;
  logic [7:0]                 space;
  logic                       len_ok;
  logic                       acc;
  logic                       is_pop;
  logic [brf_pkg::ADDR_W:0]   ring_len;
  logic [brf_pkg::ADDR_W:0]   wr_sum;
  logic [brf_pkg::ADDR_W:0]   rd_sum;
  logic                       take;

  assign req_ready = wq_ready;
  assign wq_valid  = req_valid;
  assign take      = req_valid && wq_ready;

  // Classify the request against the current fill.
  always_comb begin
    is_pop   = (req.command == brf_pkg::CMD_POP);
    space    = cap - held;
    len_ok   = (req.length <= brf_pkg::CNT_W'(brf_pkg::MAX_CHUNK));
    if (is_pop) begin
      acc = len_ok && ({4'b0, req.length} <= held);
    end else begin
      acc = len_ok && ({4'b0, req.length} <= space);
    end
  end

  // Advance the positions modulo the ring length, which is capacity plus one.
  always_comb begin
    ring_len    = {1'b0, cap} + (brf_pkg::ADDR_W+1)'(1);
    wr_sum      = {1'b0, wr_pos} + (brf_pkg::ADDR_W+1)'(req.length);
    rd_sum      = {1'b0, rd_pos} + (brf_pkg::ADDR_W+1)'(req.length);
    wr_pos_next = wr_pos;
    rd_pos_next = rd_pos;
    held_next   = held;
    if (acc && is_pop) begin
      rd_pos_next = (rd_sum >= ring_len) ? brf_pkg::ADDR_W'(rd_sum - ring_len)
                                         : rd_sum[brf_pkg::ADDR_W-1:0];
      held_next   = held - {4'b0, req.length};
    end else if (acc) begin
      wr_pos_next = (wr_sum >= ring_len) ? brf_pkg::ADDR_W'(wr_sum - ring_len)
                                         : wr_sum[brf_pkg::ADDR_W-1:0];
      held_next   = held + {4'b0, req.length};
    end
  end

  // Build the work transaction for the back end.
  always_comb begin
    wq_data.is_pop     = is_pop;
    wq_data.do_mem     = acc && (req.length != '0);
    wq_data.len        = req.length;
    wq_data.addr       = is_pop ? rd_pos : wr_pos;
    wq_data.data[0]    = req.in_byte_0;
    wq_data.data[1]    = req.in_byte_1;
    wq_data.data[2]    = req.in_byte_2;
    wq_data.data[3]    = req.in_byte_3;
    wq_data.data[4]    = req.in_byte_4;
    wq_data.data[5]    = req.in_byte_5;
    wq_data.data[6]    = req.in_byte_6;
    wq_data.data[7]    = req.in_byte_7;
    wq_data.accepted   = acc;
    wq_data.space_free = cap - held_next;
    wq_data.bytes_held = held_next;
  end

  // Position and fill registers; a capacity write empties the buffer.
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      wr_pos <= '0;
      rd_pos <= '0;
      held   <= '0;
    end else if (take) begin
      wr_pos <= wr_pos_next;
      rd_pos <= rd_pos_next;
      held   <= held_next;
    end
  end

endmodule

// ===== src/brf_queue.sv =====
// Short work queue between the front end and the back end.
// Depends on brf_pkg.
module brf_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  brf_pkg::work_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output brf_pkg::work_t pop_data
);

  localparam int PTR_W = $clog2(brf_pkg::Q_DEPTH);
  localparam int CNT_QW = $clog2(brf_pkg::Q_DEPTH + 1);

  brf_pkg::work_t     slots [brf_pkg::Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_QW-1:0]  count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CNT_QW'(brf_pkg::Q_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage for queued work.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_QW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_QW'(1);
      end
    end
  end

endmodule

// ===== src/brf_back.sv =====
// Back end: moves bytes to or from the ring memory, one per cycle, and
// holds the response register. Depends on brf_pkg.
module brf_back (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        cap,
  input  logic              q_valid,
  output logic              q_ready,
  input  brf_pkg::work_t    q_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output brf_pkg::out_item_t rsp
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_RUN,
    B_DRAIN,
    B_DONE
  } back_state_t;

  back_state_t                          state;
  brf_pkg::work_t                       cur;
  logic [brf_pkg::ADDR_W-1:0]           addr;
  logic [brf_pkg::CNT_W-1:0]            idx;
  logic [brf_pkg::MAX_CHUNK-1:0][7:0]   obuf;
  logic                                 rd_pend;
  logic [brf_pkg::IDX_W-1:0]            rd_idx;
  logic [7:0]                           rdata;
  logic [7:0]                           mem [brf_pkg::RING_SLOTS];

  logic [brf_pkg::ADDR_W-1:0]           addr_next;
  logic                                 last;
  brf_pkg::out_item_t                   rsp_next;

  assign q_ready   = (state == B_IDLE);
  assign addr_next = (addr == cap) ? '0 : addr + brf_pkg::ADDR_W'(1);
  assign last      = ((idx + brf_pkg::CNT_W'(1)) == cur.len);

  // Response built from the finished work and the collected bytes.
  always_comb begin
    rsp_next.accepted   = cur.accepted;
    rsp_next.out_byte_0 = obuf[0];
    rsp_next.out_byte_1 = obuf[1];
    rsp_next.out_byte_2 = obuf[2];
    rsp_next.out_byte_3 = obuf[3];
    rsp_next.out_byte_4 = obuf[4];
    rsp_next.out_byte_5 = obuf[5];
    rsp_next.out_byte_6 = obuf[6];
    rsp_next.out_byte_7 = obuf[7];
    rsp_next.space_free = cur.space_free;
    rsp_next.bytes_held = cur.bytes_held;
  end

  // Ring memory: one byte written or read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (state == B_RUN && !cur.is_pop) begin
      mem[addr] <= cur.data[idx[brf_pkg::IDX_W-1:0]];
    end
    rdata <= mem[addr];
  end

  // Sequencer and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      rsp_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      // A read issued in this cycle returns its byte in the next one.
      rd_pend <= (state == B_RUN) && cur.is_pop;
      // The response stays valid until taken; the next one may take its place in the same cycle.
      rsp_valid <= (state == B_DONE) || (rsp_valid && !rsp_ready);
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            cur   <= q_data;
            addr  <= q_data.addr;
            idx   <= '0;
            obuf  <= '0;
            state <= q_data.do_mem ? B_RUN : B_DONE;
          end
        end
        B_RUN: begin
          if (cur.is_pop) begin
            rd_idx <= idx[brf_pkg::IDX_W-1:0];
          end
          addr <= addr_next;
          idx  <= idx + brf_pkg::CNT_W'(1);
          if (last) begin
            state <= cur.is_pop ? B_DRAIN : B_DONE;
          end
        end
        B_DRAIN: begin
          state <= B_DONE;
        end
        B_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp   <= rsp_next;
            state <= B_IDLE;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
      // Capture a read byte in the cycle after its address was issued.
      if (rd_pend) begin
        obuf[rd_idx] <= rdata;
      end
    end
  end

endmodule

// ===== src/brf_checker.sv =====
// Port-level checker for the byte ring FIFO, bound to the top level.
// Depends on brf_pkg and byte_ring_fifo_chunked_assert.svh.
`include "byte_ring_fifo_chunked_assert.svh"

module brf_checker (
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input brf_pkg::in_item_t  req,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input brf_pkg::out_item_t rsp
);

  logic       refused_bytes_zero;
  logic [8:0] fill_sum;

  assign refused_bytes_zero = (rsp.out_byte_0 == 8'd0) && (rsp.out_byte_1 == 8'd0) &&
                              (rsp.out_byte_2 == 8'd0) && (rsp.out_byte_3 == 8'd0) &&
                              (rsp.out_byte_4 == 8'd0) && (rsp.out_byte_5 == 8'd0) &&
                              (rsp.out_byte_6 == 8'd0) && (rsp.out_byte_7 == 8'd0);
  assign fill_sum = {1'b0, rsp.space_free} + {1'b0, rsp.bytes_held};

  // A waiting request transaction keeps its contents.
  `BRF_ASSERT(a_req_hold, req_valid && !req_ready |=> req_valid && $stable(req), "request not held")

  // A stalled response transaction keeps its contents.
  `BRF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response not held")

  // A refused transaction returns no data bytes.
  `BRF_ASSERT(a_refused_zero, rsp_valid && !rsp.accepted |-> refused_bytes_zero, "refused bytes")

  // Free space and fill never add up to more than 255, the largest capacity that fits a byte.
  `BRF_ASSERT(a_fill_bound, rsp_valid |-> fill_sum <= 9'd255, "free space plus fill too large")

  // Reset leaves no response pending.
  `BRF_ASSERT_ALWAYS(a_reset_clear, rst |=> !rsp_valid, "response valid right after reset")

endmodule

bind byte_ring_fifo_chunked brf_checker u_brf_checker (.*);
